@@ rtl/srr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package srr_pkg;

	// Fixed field widths of the channels
	localparam int SEQ_W  = 3;
	localparam int DATA_W = 64;

	// Result kinds
	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_ACK  = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_DELIVER,
		S_ACK
	} state_t;

	// Per-cell control from the sequencer
	typedef struct packed {
		logic wr_en;
		logic shift;
	} cell_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/srr_in_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface srr_in_if;
	logic                       valid;
	logic                       ready;
	logic [srr_pkg::SEQ_W-1:0]  seq_num;
	logic                       checksum_ok;
	logic [srr_pkg::DATA_W-1:0] payload;

	modport source (output valid, seq_num, checksum_ok, payload, input ready);
	modport sink (input valid, seq_num, checksum_ok, payload, output ready);
endinterface

`default_nettype wire

@@ rtl/srr_out_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface srr_out_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [srr_pkg::DATA_W-1:0] data_out;
	logic [srr_pkg::SEQ_W-1:0]  ack_num;
	logic                       last;

	modport source (output valid, kind, data_out, ack_num, last, input ready);
	modport sink (input valid, kind, data_out, ack_num, last, output ready);
endinterface

`default_nettype wire

@@ rtl/srr_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One reorder slot: holds a payload and its valid mark, takes a write from
// the input side or the contents of its upper neighbor when the row slides.
module srr_cell #(
	parameter int DATA_W = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire srr_pkg::cell_ctrl_t ctrl,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic [DATA_W-1:0] nb_data,
	input  wire logic              nb_valid,
	output logic      [DATA_W-1:0] data,
	output logic                   valid
);

	logic [DATA_W-1:0] data_q;
	logic              valid_q;

	// Valid mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.wr_en) begin
			valid_q <= 1'b1;
		end else if (ctrl.shift) begin
			valid_q <= nb_valid;
		end
	end

	// Payload storage, no reset
	always_ff @(posedge clk) begin
		if (ctrl.wr_en) begin
			data_q <= wr_data;
		end else if (ctrl.shift) begin
			data_q <= nb_data;
		end
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule

`default_nettype wire

@@ rtl/selective_repeat_receiver.sv @@
// A packet at the window base is accepted in S_IDLE; S_DELIVER then
// delivers each payload from the base slot with one slide of the cell row
// and goes to S_ACK once that slot is empty, where the ack is loaded. Any
// other good packet goes straight to S_ACK, a corrupt one is dropped with
// no ack. Packets are taken only in S_IDLE; a stalled output holds each load.
// Reset (arst_n, async, active low): state, base, valid marks, output valid.
`timescale 1ns / 1ps
`default_nettype none

module selective_repeat_receiver #(
	parameter int WINDOW       = 4,
	parameter int SEQ_SPACE    = 8,
	parameter int PAYLOAD_BITS = 64
) (
	input wire logic   clk,
	input wire logic   arst_n,
	srr_in_if.sink     rx,
	srr_out_if.source  tx
);

	localparam int BW  = (SEQ_SPACE > 2) ? $clog2(SEQ_SPACE) : 1;
	localparam int IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int MW0 = (BW > srr_pkg::SEQ_W) ? BW : srr_pkg::SEQ_W;
	localparam int MW1 = ($clog2(WINDOW + 1) > MW0) ? $clog2(WINDOW + 1) : MW0;
	localparam int OW  = MW1 + 2;

	localparam logic signed [OW-1:0] NEG_WIN = OW'(-WINDOW);
	localparam logic signed [OW-1:0] WIN_S   = OW'(WINDOW);
	localparam logic signed [OW-1:0] SS_S    = OW'(SEQ_SPACE);
	localparam logic [BW-1:0]        BASE_TOP = BW'(SEQ_SPACE - 1);

	srr_pkg::state_t state_q, state_d;
	logic [BW-1:0]                 base_q;
	logic [srr_pkg::SEQ_W-1:0]     seq_q;

	logic [PAYLOAD_BITS-1:0]       cell_data  [WINDOW];
	logic                          cell_valid [WINDOW];
	srr_pkg::cell_ctrl_t           ctrl       [WINDOW];

	logic signed [OW-1:0]          off_raw, off_w;
	logic                          in_win;
	logic [IW-1:0]                 widx;
	logic                          good;
	logic                          out_free;

	logic                          rx_ready;
	logic                          load, shift, base_inc;
	logic                          ld_kind, ld_last;
	logic [srr_pkg::DATA_W-1:0]    ld_data;
	logic [srr_pkg::SEQ_W-1:0]     ld_ack;

	logic                          out_valid_q, kind_q, last_q;
	logic [srr_pkg::DATA_W-1:0]    data_q;
	logic [srr_pkg::SEQ_W-1:0]     ack_q;

	// Offset of the arriving packet from the window base
	always_comb begin
		off_raw = $signed(OW'(rx.seq_num)) - $signed(OW'(base_q));
		off_w   = (off_raw < NEG_WIN) ? (off_raw + SS_S) : off_raw;
		in_win  = (off_w >= 0) && (off_w < WIN_S);
		widx    = off_w[IW-1:0];
	end

	assign good     = rx.valid && rx_ready && rx.checksum_ok;
	assign out_free = !out_valid_q || tx.ready;

	// Row of reorder cells; the top cell takes an empty slot on a slide
	for (genvar i = 0; i < WINDOW; i++) begin : g_cell
		assign ctrl[i].wr_en = good && in_win && (widx == IW'(i));
		assign ctrl[i].shift = shift;

		if (i < WINDOW - 1) begin : g_mid
			srr_cell #(.DATA_W(PAYLOAD_BITS)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl[i]),
				.wr_data  (rx.payload[PAYLOAD_BITS-1:0]),
				.nb_data  (cell_data[i+1]),
				.nb_valid (cell_valid[i+1]),
				.data     (cell_data[i]),
				.valid    (cell_valid[i])
			);
		end else begin : g_top
			srr_cell #(.DATA_W(PAYLOAD_BITS)) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl[i]),
				.wr_data  (rx.payload[PAYLOAD_BITS-1:0]),
				.nb_data  (cell_data[i]),
				.nb_valid (1'b0),
				.data     (cell_data[i]),
				.valid    (cell_valid[i])
			);
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srr_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, delivery and ack loading
	always_comb begin
		state_d  = state_q;
		rx_ready = 1'b0;
		load     = 1'b0;
		shift    = 1'b0;
		base_inc = 1'b0;
		ld_kind  = srr_pkg::KIND_DATA;
		ld_data  = srr_pkg::DATA_W'(cell_data[0]);
		ld_ack   = '0;
		ld_last  = 1'b0;
		case (state_q)
			srr_pkg::S_IDLE: begin
				rx_ready = 1'b1;
				if (rx.valid && rx.checksum_ok) begin
					if (in_win && (off_w == '0)) begin
						state_d = srr_pkg::S_DELIVER;
					end else begin
						state_d = srr_pkg::S_ACK;
					end
				end
			end
			srr_pkg::S_DELIVER: begin
				if (!cell_valid[0]) begin
					state_d = srr_pkg::S_ACK;
				end else if (out_free) begin
					load     = 1'b1;
					shift    = 1'b1;
					base_inc = 1'b1;
				end
			end
			srr_pkg::S_ACK: begin
				if (out_free) begin
					load    = 1'b1;
					ld_kind = srr_pkg::KIND_ACK;
					ld_data = '0;
					ld_ack  = seq_q;
					ld_last = 1'b1;
					state_d = srr_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = srr_pkg::S_IDLE;
			end
		endcase
	end

	assign rx.ready = rx_ready;

	// Window base and captured sequence number
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
		end else if (base_inc) begin
			base_q <= (base_q == BASE_TOP) ? '0 : base_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (good) begin
			seq_q <= rx.seq_num;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (tx.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= ld_kind;
			data_q <= ld_data;
			ack_q  <= ld_ack;
			last_q <= ld_last;
		end
	end

	assign tx.valid    = out_valid_q;
	assign tx.kind     = kind_q;
	assign tx.data_out = data_q;
	assign tx.ack_num  = ack_q;
	assign tx.last     = last_q;

	// Only the ack closes a packet's results
	a_last_is_ack: assert property (@(posedge clk) disable iff (!arst_n)
		tx.valid |-> (tx.last == tx.kind))
		else $error("last flag on a non-ack result");

	// A delivery is loaded only from a valid base slot
	a_deliver_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(load && (ld_kind == srr_pkg::KIND_DATA)) |-> cell_valid[0])
		else $error("delivery from an empty slot");

	// Between packets the base slot is always empty
	a_idle_base_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srr_pkg::S_IDLE) |-> !cell_valid[0])
		else $error("base slot still valid while idle");

	// The base moves only during a delivery run
	a_base_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(base_q) |-> $past(state_q == srr_pkg::S_DELIVER))
		else $error("base changed outside delivery");

endmodule

`default_nettype wire
